### src/mlft_pkg.sv
`default_nettype none

package mlft_pkg;

    localparam int PORTS         = 8;
    localparam int TABLE_ENTRIES = 64;
    localparam int MATRIX_SIDE   = 8;
    localparam int MAC_W         = 48;
    localparam int PORT_W        = 3;
    localparam int MASK_W        = MATRIX_SIDE;
    localparam int PERM_W        = MATRIX_SIDE * MATRIX_SIDE;
    localparam int ACTIVE_W      = 4;
    localparam int PORT_LIM_W    = $clog2(PORTS + 1);
    localparam int COUNT_W       = $clog2(TABLE_ENTRIES + 1);
    localparam int GROUP_SIZE    = 8;
    localparam int NUM_GROUPS    = (TABLE_ENTRIES + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 64;

    localparam logic [MAC_W-1:0] BCAST_MAC = {MAC_W{1'b1}};

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SEND_PERMISSION = 2'd0,
        CFG_ACTIVE_PORTS    = 2'd1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COMPARE,
        ST_REDUCE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [MAC_W-1:0]  mac;
        logic [PORT_W-1:0] port;
    } entry_t;

    typedef struct packed {
        logic              src_hit;
        logic              dst_hit;
        logic [PORT_W-1:0] port;
    } cell_hit_t;

    typedef struct packed {
        logic              src_found;
        logic              dst_found;
        logic [PORT_W-1:0] dst_port;
    } match_t;

endpackage

`default_nettype wire

### src/mlft_cell.sv
`default_nettype none

module mlft_cell (
    input  wire                       aclk,
    input  wire                       shift_en,
    input  wire                       occupied,
    input  mlft_pkg::entry_t          entry_in,
    input  wire [mlft_pkg::MAC_W-1:0] key_src_mac,
    input  wire [mlft_pkg::MAC_W-1:0] key_dst_mac,
    output mlft_pkg::entry_t          entry_out,
    output mlft_pkg::cell_hit_t       hit_out
);

    mlft_pkg::entry_t    entry_reg;
    mlft_pkg::cell_hit_t hit_reg;
    mlft_pkg::cell_hit_t hit_next;

    always_comb begin
        hit_next.src_hit = occupied && (entry_reg.mac == key_src_mac);
        hit_next.dst_hit = occupied && (entry_reg.mac == key_dst_mac);
        hit_next.port    = entry_reg.port;
    end

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            entry_reg <= entry_in;
        end
        hit_reg <= hit_next;
    end

    assign entry_out = entry_reg;
    assign hit_out   = hit_reg;

endmodule

`default_nettype wire

### src/mlft_match_reduce.sv
`default_nettype none

module mlft_match_reduce (
    input  wire                 aclk,
    input  mlft_pkg::cell_hit_t hits [mlft_pkg::TABLE_ENTRIES],
    output mlft_pkg::match_t    match
);

    mlft_pkg::match_t grp_reg  [mlft_pkg::NUM_GROUPS];
    mlft_pkg::match_t grp_next [mlft_pkg::NUM_GROUPS];

    for (genvar g = 0; g < mlft_pkg::NUM_GROUPS; g++) begin : g_group
        always_comb begin
            grp_next[g] = '0;
            for (int k = 0; k < mlft_pkg::GROUP_SIZE; k++) begin
                if (g * mlft_pkg::GROUP_SIZE + k < mlft_pkg::TABLE_ENTRIES) begin
                    grp_next[g].src_found = grp_next[g].src_found
                        | hits[g * mlft_pkg::GROUP_SIZE + k].src_hit;
                    grp_next[g].dst_found = grp_next[g].dst_found
                        | hits[g * mlft_pkg::GROUP_SIZE + k].dst_hit;
                    if (hits[g * mlft_pkg::GROUP_SIZE + k].dst_hit) begin
                        grp_next[g].dst_port = grp_next[g].dst_port
                            | hits[g * mlft_pkg::GROUP_SIZE + k].port;
                    end
                end
            end
        end

        always_ff @(posedge aclk) begin
            grp_reg[g] <= grp_next[g];
        end
    end

    always_comb begin
        match = '0;
        for (int g = 0; g < mlft_pkg::NUM_GROUPS; g++) begin
            match.src_found = match.src_found | grp_reg[g].src_found;
            match.dst_found = match.dst_found | grp_reg[g].dst_found;
            match.dst_port  = match.dst_port  | grp_reg[g].dst_port;
        end
    end

endmodule

`default_nettype wire

### src/mac_learning_forward_table.sv
// Learning forwarding table for a small Ethernet switch.
// The input channel (s_valid/s_ready) carries one frame header per transaction:
// ingress port, source MAC and destination MAC. The result channel
// (m_valid/m_ready) returns one transaction per header with the forwarding
// port mask and the learned, table_full and dest_known flags.
// Entries live in a chain of cells; a newly learned entry enters the first cell
// and every occupied entry moves one cell down. Each cell compares both MACs
// against its entry, and the hits are merged by a registered OR tree.
// A header is accepted in the idle state; the compare, the group merge and
// the final merge with the learn decision follow in the compare, reduce and
// finish states, each registered, and the next header is accepted only after
// the result of the last one has been registered on leaving the finish state.
// Configuration writes through cfg_wr_en take effect at once and are meant
// for times when no header is in flight.
// Reset empties the table, clears the permission matrix and sets all eight
// ports active. If the receiver stalls, the result is held in the output
// register, one more header can be taken and worked up to its final cycle,
// and learning for that header waits until the output register is free.
`default_nettype none

module mac_learning_forward_table (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              cfg_wr_en,
    input  wire [mlft_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire [mlft_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    input  wire                              s_valid,
    output logic                             s_ready,
    input  wire [mlft_pkg::PORT_W-1:0]       s_src_port,
    input  wire [mlft_pkg::MAC_W-1:0]        s_src_mac,
    input  wire [mlft_pkg::MAC_W-1:0]        s_dest_mac,
    output logic                             m_valid,
    input  wire                              m_ready,
    output logic [mlft_pkg::MASK_W-1:0]      m_dest_mask,
    output logic                             m_learned,
    output logic                             m_table_full,
    output logic                             m_dest_known
);

    mlft_pkg::state_t state_reg, state_next;

    logic [mlft_pkg::PERM_W-1:0]   send_permission_reg;
    logic [mlft_pkg::ACTIVE_W-1:0] active_ports_reg;
    logic [mlft_pkg::COUNT_W-1:0]  count_reg;

    logic [mlft_pkg::PORT_W-1:0] src_port_reg;
    logic [mlft_pkg::MAC_W-1:0]  src_mac_reg;
    logic [mlft_pkg::MAC_W-1:0]  dest_mac_reg;

    logic                        m_valid_reg;
    logic [mlft_pkg::MASK_W-1:0] dest_mask_reg, dest_mask_next;
    logic                        learned_reg;
    logic                        table_full_reg;
    logic                        dest_known_reg, dest_known_next;

    mlft_pkg::entry_t    chain [mlft_pkg::TABLE_ENTRIES];
    mlft_pkg::cell_hit_t hits  [mlft_pkg::TABLE_ENTRIES];
    mlft_pkg::entry_t    new_entry;
    mlft_pkg::match_t    match;

    logic                            out_free;
    logic                            commit;
    logic                            is_full;
    logic                            do_learn;
    logic                            shift_en;
    logic                            dst_found;
    logic [mlft_pkg::PORT_W-1:0]     dst_port;
    logic [mlft_pkg::PORT_LIM_W-1:0] port_limit;
    logic [mlft_pkg::MATRIX_SIDE-1:0] perm_row;
    logic [mlft_pkg::MASK_W-1:0]     allow;

    assign out_free = !m_valid_reg || m_ready;
    assign commit   = (state_reg == mlft_pkg::ST_FINISH) && out_free;
    assign is_full  = (count_reg == mlft_pkg::COUNT_W'(mlft_pkg::TABLE_ENTRIES));
    assign do_learn = !is_full && !match.src_found && (src_mac_reg != mlft_pkg::BCAST_MAC);
    assign shift_en = commit && do_learn;

    assign new_entry.mac  = src_mac_reg;
    assign new_entry.port = src_port_reg;

    for (genvar i = 0; i < mlft_pkg::TABLE_ENTRIES; i++) begin : g_cell
        mlft_cell u_cell (
            .aclk        (aclk),
            .shift_en    (shift_en),
            .occupied    (count_reg > mlft_pkg::COUNT_W'(i)),
            .entry_in    ((i == 0) ? new_entry : chain[(i == 0) ? 0 : i - 1]),
            .key_src_mac (src_mac_reg),
            .key_dst_mac (dest_mac_reg),
            .entry_out   (chain[i]),
            .hit_out     (hits[i])
        );
    end

    mlft_match_reduce u_reduce (
        .aclk  (aclk),
        .hits  (hits),
        .match (match)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mlft_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        case (state_reg)
            mlft_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = mlft_pkg::ST_COMPARE;
                end
            end
            mlft_pkg::ST_COMPARE: begin
                state_next = mlft_pkg::ST_REDUCE;
            end
            mlft_pkg::ST_REDUCE: begin
                state_next = mlft_pkg::ST_FINISH;
            end
            mlft_pkg::ST_FINISH: begin
                if (out_free) begin
                    state_next = mlft_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mlft_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (32'(active_ports_reg) > mlft_pkg::PORTS) begin
            port_limit = mlft_pkg::PORT_LIM_W'(mlft_pkg::PORTS);
        end else begin
            port_limit = mlft_pkg::PORT_LIM_W'(active_ports_reg);
        end
        perm_row = send_permission_reg[src_port_reg * mlft_pkg::MATRIX_SIDE +: mlft_pkg::MATRIX_SIDE];
        for (int p = 0; p < mlft_pkg::MASK_W; p++) begin
            allow[p] = (p < mlft_pkg::PORTS) && (p < 32'(port_limit)) && perm_row[p];
        end

        // A frame whose source and destination match sees the entry it learns.
        dst_found = match.dst_found || (do_learn && (dest_mac_reg == src_mac_reg));
        dst_port  = match.dst_found ? match.dst_port : src_port_reg;

        if (dest_mac_reg == mlft_pkg::BCAST_MAC) begin
            dest_mask_next  = allow & ~(mlft_pkg::MASK_W'(1) << src_port_reg);
            dest_known_next = 1'b0;
        end else begin
            dest_known_next = dst_found;
            if (dst_found) begin
                dest_mask_next = allow & (mlft_pkg::MASK_W'(1) << dst_port);
            end else begin
                dest_mask_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            send_permission_reg <= '0;
            active_ports_reg    <= mlft_pkg::ACTIVE_W'(8);
        end else if (cfg_wr_en) begin
            case (mlft_pkg::cfg_reg_t'(cfg_index))
                mlft_pkg::CFG_SEND_PERMISSION: begin
                    send_permission_reg <= cfg_wr_data[mlft_pkg::PERM_W-1:0];
                end
                mlft_pkg::CFG_ACTIVE_PORTS: begin
                    active_ports_reg <= cfg_wr_data[mlft_pkg::ACTIVE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (shift_en) begin
                count_reg <= count_reg + mlft_pkg::COUNT_W'(1);
            end
            if (commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            src_port_reg <= s_src_port;
            src_mac_reg  <= s_src_mac;
            dest_mac_reg <= s_dest_mac;
        end
        if (commit) begin
            dest_mask_reg  <= dest_mask_next;
            learned_reg    <= do_learn;
            table_full_reg <= is_full;
            dest_known_reg <= dest_known_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_dest_mask  = dest_mask_reg;
    assign m_learned    = learned_reg;
    assign m_table_full = table_full_reg;
    assign m_dest_known = dest_known_reg;

`ifndef ASSERT_OFF
    a_learn_excludes_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_learned && m_table_full))
        else $error("learned and table_full are both set");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= mlft_pkg::COUNT_W'(mlft_pkg::TABLE_ENTRIES))
        else $error("entry count exceeds table size");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        shift_en |=> (count_reg == $past(count_reg) + mlft_pkg::COUNT_W'(1)))
        else $error("entry count did not advance on learn");

    a_count_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !shift_en |=> $stable(count_reg))
        else $error("entry count changed without a learn");
`endif

endmodule

`default_nettype wire

### verif/mac_learning_forward_table_tb.sv
`timescale 1ns / 1ps

module mac_learning_forward_table_tb;
    import mlft_pkg::*;

    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_FRAMES   = 230;
    localparam int FRESH_PCT      = 6;

    typedef struct packed {
        logic [MASK_W-1:0] dest_mask;
        logic              learned;
        logic              table_full;
        logic              dest_known;
    } fwd_result_t;

    logic                   aclk        = 1'b0;
    logic                   aresetn     = 1'b0;
    logic                   cfg_wr_en   = 1'b0;
    cfg_reg_t               cfg_index   = CFG_SEND_PERMISSION;
    logic [CFG_DATA_W-1:0]  cfg_wr_data = '0;
    logic                   s_valid     = 1'b0;
    logic                   s_ready;
    logic [PORT_W-1:0]      s_src_port  = '0;
    logic [MAC_W-1:0]       s_src_mac   = '0;
    logic [MAC_W-1:0]       s_dest_mac  = '0;
    logic                   m_valid;
    logic                   m_ready     = 1'b0;
    logic [MASK_W-1:0]      m_dest_mask;
    logic                   m_learned;
    logic                   m_table_full;
    logic                   m_dest_known;

    logic [PERM_W-1:0]      perm_matrix  = '0;
    logic [ACTIVE_W-1:0]    active_count = 4'd8;
    logic [MAC_W-1:0]       table_mac [TABLE_ENTRIES];
    logic [PORT_W-1:0]      table_port [TABLE_ENTRIES];
    int                     table_fill = 0;
    fwd_result_t            pending_fwd [$];
    logic [MAC_W-1:0]       used_macs [$];

    int   error_count    = 0;
    int   frame_count    = 0;
    int   result_count   = 0;
    int   setting_count  = 0;
    int   src_idle_pct   = 0;
    int   sink_stall_pct = 0;
    logic hold_req       = 1'b0;
    logic hold_done      = 1'b0;
    int   hold_count     = 0;
    int   quiet_cycles   = 0;

    mac_learning_forward_table dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_src_port   (s_src_port),
        .s_src_mac    (s_src_mac),
        .s_dest_mac   (s_dest_mac),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_dest_mask  (m_dest_mask),
        .m_learned    (m_learned),
        .m_table_full (m_table_full),
        .m_dest_known (m_dest_known)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic flag_error(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic int find_entry(input logic [MAC_W-1:0] mac);
        for (int i = 0; i < table_fill; i++) begin
            if (table_mac[i] == mac) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic logic may_send(input int from, input int to);
        int limit;
        limit = (active_count > PORTS) ? PORTS : int'(active_count);
        if (to >= limit) begin
            return 1'b0;
        end
        return perm_matrix[from * MATRIX_SIDE + to];
    endfunction

    function automatic fwd_result_t forward_decision(input logic [PORT_W-1:0] port,
                                                     input logic [MAC_W-1:0] smac,
                                                     input logic [MAC_W-1:0] dmac);
        fwd_result_t r;
        int          hit;
        r = '0;
        if (table_fill >= TABLE_ENTRIES) begin
            r.table_full = 1'b1;
        end else if (find_entry(smac) < 0 && smac != BCAST_MAC) begin
            table_mac[table_fill]  = smac;
            table_port[table_fill] = port;
            table_fill++;
            r.learned = 1'b1;
        end
        if (dmac == BCAST_MAC) begin
            for (int p = 0; p < MATRIX_SIDE; p++) begin
                if (p != int'(port) && may_send(int'(port), p)) begin
                    r.dest_mask[p] = 1'b1;
                end
            end
        end else begin
            hit = find_entry(dmac);
            if (hit >= 0) begin
                r.dest_known = 1'b1;
                if (may_send(int'(port), int'(table_port[hit]))) begin
                    r.dest_mask[table_port[hit]] = 1'b1;
                end
            end
        end
        return r;
    endfunction

    // Results are checked before the new header is predicted so that a header
    // accepted at the same edge can never be matched against this result.
    always @(posedge aclk) begin
        fwd_result_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                result_count++;
                if (pending_fwd.size() == 0) begin
                    flag_error($sformatf("result with nothing expected, mask %h",
                                         m_dest_mask));
                end else begin
                    want = pending_fwd.pop_front();
                    if (m_dest_mask !== want.dest_mask)
                        flag_error($sformatf("dest_mask %h, expected %h",
                                             m_dest_mask, want.dest_mask));
                    if (m_learned !== want.learned)
                        flag_error($sformatf("learned %b, expected %b",
                                             m_learned, want.learned));
                    if (m_table_full !== want.table_full)
                        flag_error($sformatf("table_full %b, expected %b",
                                             m_table_full, want.table_full));
                    if (m_dest_known !== want.dest_known)
                        flag_error($sformatf("dest_known %b, expected %b",
                                             m_dest_known, want.dest_known));
                end
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_SEND_PERMISSION: perm_matrix = cfg_wr_data[PERM_W-1:0];
                    CFG_ACTIVE_PORTS: active_count = cfg_wr_data[ACTIVE_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                frame_count++;
                pending_fwd.push_back(forward_decision(s_src_port, s_src_mac, s_dest_mac));
            end
        end
    end

    always @(posedge aclk) begin
        if (hold_req && !hold_done) begin
            m_ready    <= 1'b0;
            hold_count <= hold_count + 1;
            if (hold_count + 1 >= HOLD_CYCLES) begin
                hold_done <= 1'b1;
            end
        end else begin
            if (!hold_req) begin
                hold_done  <= 1'b0;
                hold_count <= 0;
            end
            m_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || cfg_wr_en || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles.", WATCHDOG_LIMIT);
            $display("mac_learning_forward_table_tb: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [MAC_W-1:0] random_mac();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        return w[MAC_W-1:0];
    endfunction

    task automatic send_frame(input logic [PORT_W-1:0] port, input logic [MAC_W-1:0] smac,
                              input logic [MAC_W-1:0] dmac);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_src_port <= port;
        s_src_mac  <= smac;
        s_dest_mac <= dmac;
        if (smac != BCAST_MAC) begin
            used_macs.push_back(smac);
        end
        do begin
            @(posedge aclk);
        end while (!s_ready);
    endtask

    // Most sources repeat earlier ones so that lookups hit; a few are new and
    // slowly fill the table over the run.
    task automatic random_frame();
        logic [MAC_W-1:0] smac;
        logic [MAC_W-1:0] dmac;
        int               pick;
        pick = $urandom_range(0, 99);
        if (pick < FRESH_PCT || used_macs.size() == 0) begin
            smac = random_mac();
        end else if (pick < FRESH_PCT + 8) begin
            smac = BCAST_MAC;
        end else begin
            smac = used_macs[$urandom_range(0, used_macs.size() - 1)];
        end
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
            dmac = BCAST_MAC;
        end else if (pick < 30 || used_macs.size() == 0) begin
            dmac = random_mac();
        end else begin
            dmac = used_macs[$urandom_range(0, used_macs.size() - 1)];
        end
        send_frame(PORT_W'($urandom_range(0, MATRIX_SIDE - 1)), smac, dmac);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_fwd.size() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic cfg_write(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic apply_config(input logic [PERM_W-1:0] perm,
                                input logic [ACTIVE_W-1:0] active);
        logic [63:0] w;
        drain_results();
        w = {$urandom(), $urandom()};
        w[ACTIVE_W-1:0] = active;
        cfg_write(CFG_SEND_PERMISSION, perm);
        cfg_write(CFG_ACTIVE_PORTS, w);
        setting_count++;
    endtask

    function automatic logic [PERM_W-1:0] random_perm();
        return {$urandom(), $urandom()};
    endfunction

    task automatic test_directed_learning();
        logic [MAC_W-1:0] mac_a, mac_b, mac_c, mac_d;
        mac_a = 48'h0200_0000_000A;
        mac_b = 48'h0200_0000_000B;
        mac_c = 48'h0200_0000_000C;
        mac_d = 48'h0200_0000_000D;
        src_idle_pct   <= 0;
        sink_stall_pct <= 0;
        apply_config('1, 4'd8);
        send_frame(3'd0, mac_a, BCAST_MAC);
        send_frame(3'd7, mac_b, mac_a);
        send_frame(3'd3, mac_a, mac_b);
        send_frame(3'd7, mac_c, mac_b);
        send_frame(3'd5, mac_d, mac_d);
        send_frame(3'd2, BCAST_MAC, mac_a);
        send_frame(3'd4, 48'h0200_0000_000E, 48'h0200_0000_00FF);
        send_frame(3'd1, '0, '0);
        send_frame(3'd6, BCAST_MAC, BCAST_MAC);
        send_frame(3'd6, 48'hFFFF_FFFF_FFFE, 48'h7FFF_FFFF_FFFF);
        send_frame(3'd0, 48'h8000_0000_0000, 48'hFFFF_FFFF_FFFE);
    endtask

    task automatic test_port_limits();
        logic [MAC_W-1:0] mac_a, mac_b, mac_d;
        logic [PERM_W-1:0] one_path;
        mac_a = 48'h0200_0000_000A;
        mac_b = 48'h0200_0000_000B;
        mac_d = 48'h0200_0000_000D;
        apply_config('1, 4'd0);
        send_frame(3'd1, mac_a, BCAST_MAC);
        send_frame(3'd1, mac_a, mac_b);
        apply_config('1, 4'd15);
        send_frame(3'd3, 48'h0200_0000_0010, BCAST_MAC);
        apply_config('1, 4'd1);
        send_frame(3'd4, 48'h0200_0000_0011, mac_a);
        send_frame(3'd2, 48'h0200_0000_0011, BCAST_MAC);
        send_frame(3'd0, mac_a, BCAST_MAC);
        apply_config('1, 4'd2);
        send_frame(3'd6, 48'h0200_0000_0012, BCAST_MAC);
        send_frame(3'd7, mac_b, 48'h0200_0000_0012);
        one_path = '0;
        one_path[3 * MATRIX_SIDE + 5] = 1'b1;
        apply_config(one_path, 4'd8);
        send_frame(3'd3, 48'h0200_0000_0013, mac_d);
        send_frame(3'd5, 48'h0200_0000_0014, mac_d);
        apply_config('0, 4'd8);
        send_frame(3'd2, mac_a, mac_b);
    endtask

    task automatic run_phase(input logic [PERM_W-1:0] perm, input logic [ACTIVE_W-1:0] active,
                             input int src_idle, input int sink_stall);
        apply_config(perm, active);
        src_idle_pct   <= src_idle;
        sink_stall_pct <= sink_stall;
        repeat (PHASE_FRAMES) random_frame();
    endtask

    task automatic test_random_traffic();
        run_phase('1, 4'd8, 0, 0);
        run_phase(random_perm(), 4'd15, 58, 0);
        run_phase(random_perm(), 4'd3, 0, 58);
        run_phase(random_perm(), 4'd1, 23, 23);
        run_phase('0, 4'd8, 58, 0);
        run_phase(random_perm(), 4'd0, 0, 58);
        run_phase(random_perm() | random_perm(), 4'd6, 23, 23);
    endtask

    task automatic test_backpressure();
        apply_config('1, 4'd8);
        src_idle_pct   <= 0;
        sink_stall_pct <= 0;
        hold_req <= 1'b1;
        fork
            repeat (16) random_frame();
            begin
                wait (hold_done);
                hold_req <= 1'b0;
            end
        join
    endtask

    task automatic test_paused_sender();
        src_idle_pct   <= 23;
        sink_stall_pct <= 23;
        repeat (12) random_frame();
        drain_results();
        repeat (12) random_frame();
    endtask

    task automatic test_full_table();
        apply_config(random_perm(), 4'd8);
        while (table_fill < TABLE_ENTRIES) begin
            send_frame(PORT_W'($urandom_range(0, MATRIX_SIDE - 1)), random_mac(), BCAST_MAC);
            drain_results();
        end
        send_frame(3'd2, used_macs[0], used_macs[1]);
        send_frame(3'd5, BCAST_MAC, BCAST_MAC);
        send_frame(3'd7, random_mac(), used_macs[0]);
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_learning();
        test_port_limits();
        test_random_traffic();
        test_backpressure();
        test_paused_sender();
        test_full_table();
        drain_results();
        repeat (8) @(posedge aclk);
        if (pending_fwd.size() != 0) begin
            flag_error($sformatf("%0d results never arrived", pending_fwd.size()));
        end
        $display("Sent %0d frame headers under %0d settings; checked %0d results.",
                 frame_count, setting_count, result_count);
        $display("Table ended with %0d of %0d entries after a long stall and a drain pause.",
                 table_fill, TABLE_ENTRIES);
        if (error_count == 0) begin
            $display("mac_learning_forward_table_tb: clean");
        end else begin
            $display("mac_learning_forward_table_tb: errors");
        end
        $finish;
    end

endmodule
